@@ hdl/slir_pkg.sv @@
package slir_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 8;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int CNT_OUT_W = 7;
   localparam int RSP_W    = 24;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   // broadcast to every cell of the row
   typedef struct packed {
      mode_type         mode;
      logic [KEY_W-1:0] key;
      logic             commit;
   } op_type;

endpackage

@@ hdl/slir_cell.sv @@
module slir_cell
   import slir_pkg::*;
(
   input  logic             clock,
   input  op_type           op,
   input  logic             occupied,
   input  logic             lt_left,
   input  logic [KEY_W-1:0] key_left,
   input  logic [KEY_W-1:0] key_right,
   output logic             lt,
   output logic             hit,
   output logic [KEY_W-1:0] key,
   output logic [KEY_W-1:0] key_nxt
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             at_pos;

   // first cell whose key is not below the request key
   assign lt     = occupied && (key_ff < op.key);
   assign at_pos = !lt && lt_left;
   assign hit    = at_pos && occupied && (key_ff == op.key);

   always_comb begin
      priority if (lt) begin
         key_in = key_ff;
      end else if (op.mode == MODE_INSERT) begin
         key_in = at_pos ? op.key : key_left;
      end else begin
         key_in = key_right;
      end
   end

   assign key_nxt = op.commit ? key_in : key_ff;
   assign key     = key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_nxt;
   end

endmodule

@@ hdl/sorted_list_insert_remove.sv @@
// Response: registered; it shows at rsp_tvalid in the cycle after its request is accepted.
// Throughput: one request per cycle while req_tready is high; the whole row of cells compares
//   the request key and shifts its contents in the same cycle, which sets the clock period.
// Reset: synchronous, clears the entry count and the response valid; the stored keys
//   are left as they are and only entries below the count are ever used.
module sorted_list_insert_remove
   import slir_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [KEY_W-1:0] req_tdata,  // [7:0] key
   input  logic             req_tuser,  // [0] mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // [0] success, [7:1] entry_count,
                                         // [8] table_empty, [16:9] smallest_key, rest zero
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               accept;
   mode_type           mode;
   op_type             op;
   logic               full;
   logic               found;
   logic               success;

   logic [CAPACITY-1:0] occ;
   logic [CAPACITY-1:0] lt_w;
   logic [CAPACITY-1:0] hit_w;
   logic [KEY_W-1:0]    key_w   [CAPACITY];
   logic [KEY_W-1:0]    nxt_w   [CAPACITY];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign mode       = mode_type'(req_tuser);

   assign full  = (count_ff == COUNT_W'(CAPACITY));
   assign found = |hit_w;

   always_comb begin
      unique case (mode)
         MODE_INSERT: success = !full;
         MODE_REMOVE: success = found;
         default:     success = 1'b0;
      endcase
   end

   assign op.mode   = mode;
   assign op.key    = req_tdata;
   assign op.commit = accept && success;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic             lt_left;
      logic [KEY_W-1:0] key_left;
      logic [KEY_W-1:0] key_right;

      assign occ[i] = (COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign lt_left  = 1'b1;
         assign key_left = req_tdata;
      end else begin : g_mid
         assign lt_left  = lt_w[i-1];
         assign key_left = key_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign key_right = key_w[i];
      end else begin : g_body
         assign key_right = key_w[i+1];
      end

      slir_cell u_cell (
         .clock     (clock),
         .op        (op),
         .occupied  (occ[i]),
         .lt_left   (lt_left),
         .key_left  (key_left),
         .key_right (key_right),
         .lt        (lt_w[i]),
         .hit       (hit_w[i]),
         .key       (key_w[i]),
         .key_nxt   (nxt_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (op.commit) begin
         unique case (mode)
            MODE_INSERT: count_in = count_ff + COUNT_W'(1);
            MODE_REMOVE: count_in = count_ff - COUNT_W'(1);
            default:     count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[0]   = success;
         rsp_data_in[7:1] = CNT_OUT_W'(count_in);
         rsp_data_in[8]   = (count_in == '0);
         rsp_data_in[16:9] = (count_in == '0) ? '0 : nxt_w[0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (mode == MODE_INSERT) && !full |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("insert did not grow the count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      occ[1] |-> key_w[0] <= key_w[1])
      else $error("first two keys out of order");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[8] == (rsp_data_ff[7:1] == '0))
      else $error("empty flag disagrees with count");

endmodule

@@ tb/testbench.sv @@
module testbench
   import slir_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES      = 4;
   localparam int PHASE_ITEMS = 125;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      mode_type         mode;
      logic [KEY_W-1:0] key;
   } key_req_type;

   typedef struct packed {
      logic                 success;
      logic [CNT_OUT_W-1:0] entry_count;
      logic                 table_empty;
      logic [KEY_W-1:0]     smallest_key;
   } store_status_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [KEY_W-1:0] req_tdata = '0;   // [7:0] key
   logic             req_tuser = 1'b0; // [0] mode
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // [0] success, [7:1] entry_count,
                                       // [8] table_empty, [16:9] smallest_key

   sorted_list_insert_remove u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // predicted contents of the store
   logic [KEY_W-1:0] held_keys [CAPACITY];
   int               held_count = 0;
   store_status_type expected_status[$];

   // stimulus side
   key_req_type      pending_reqs[$];
   logic [KEY_W-1:0] gen_keys[$];   // keys the generator believes are stored
   key_req_type      cur_req;
   int               n_queued = 0;
   int               n_accepted = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               hold_requests = 0;
   int               hold_served = 0;
   int               hold_left = 0;
   int               mismatches = 0;
   int               cycle_count = 0;

   function automatic store_status_type apply_request(key_req_type r);
      store_status_type st;
      int               pos;
      logic             ok;
      pos = 0;
      ok  = 1'b0;
      if (r.mode == MODE_INSERT) begin
         if (held_count < CAPACITY) begin
            while (pos < held_count && held_keys[pos] < r.key) pos++;
            for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
            held_keys[pos] = r.key;
            held_count++;
            ok = 1'b1;
         end
      end else begin
         while (pos < held_count && held_keys[pos] != r.key) pos++;
         if (pos < held_count) begin
            for (int i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
            held_count--;
            ok = 1'b1;
         end
      end
      st.success      = ok;
      st.entry_count  = CNT_OUT_W'(held_count);
      st.table_empty  = (held_count == 0);
      st.smallest_key = (held_count == 0) ? '0 : held_keys[0];
      return st;
   endfunction

   task automatic queue_req(mode_type m, logic [KEY_W-1:0] k);
      key_req_type r;
      r.mode = m;
      r.key  = k;
      pending_reqs.push_back(r);
      n_queued++;
      if (m == MODE_INSERT) begin
         if (gen_keys.size() < CAPACITY) gen_keys.push_back(k);
      end else begin
         for (int i = 0; i < gen_keys.size(); i++) begin
            if (gen_keys[i] == k) begin
               gen_keys.delete(i);
               break;
            end
         end
      end
   endtask

   // narrow ranges give plenty of duplicates
   function automatic logic [KEY_W-1:0] pick_key(bit narrow, int lo);
      return narrow ? KEY_W'(lo + $urandom_range(0, 7)) : KEY_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [KEY_W-1:0] stored_key();
      return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
   endfunction

   // runs on past capacity so a few inserts are refused
   task automatic fill_store(bit narrow, int lo);
      int n;
      n = CAPACITY - gen_keys.size() + $urandom_range(1, 3);
      repeat (n) queue_req(MODE_INSERT, pick_key(narrow, lo));
   endtask

   task automatic drain_store(bit narrow, int lo);
      while (gen_keys.size() != 0) begin
         if ($urandom_range(0, 9) == 0) queue_req(MODE_REMOVE, pick_key(narrow, lo));
         else queue_req(MODE_REMOVE, stored_key());
      end
      queue_req(MODE_REMOVE, KEY_W'($urandom_range(0, 255)));
   endtask

   task automatic random_burst();
      int bias;
      bit narrow;
      int lo;
      narrow = $urandom_range(0, 1);
      lo     = $urandom_range(0, 248);
      case ($urandom_range(0, 3))
         0: fill_store(narrow, lo);
         1: drain_store(narrow, lo);
         default: begin
            bias = $urandom_range(20, 80);
            repeat (16) begin
               if ($urandom_range(0, 99) < bias) queue_req(MODE_INSERT, pick_key(narrow, lo));
               else if (gen_keys.size() != 0 && $urandom_range(0, 3) != 0)
                  queue_req(MODE_REMOVE, stored_key());
               else queue_req(MODE_REMOVE, pick_key(narrow, lo));
            end
         end
      endcase
   endtask

   task automatic wait_drained();
      while (n_accepted != n_queued || expected_status.size() != 0) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_status.push_back(apply_request(cur_req));
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= cur_req.key;
               req_tuser  <= cur_req.mode;
            end else begin
               req_tvalid <= 1'b0;
               req_tdata  <= KEY_W'($urandom);
               req_tuser  <= 1'($urandom);
            end
         end
      end
   end

   // long receiver hold, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   // monitor and response back-pressure
   always @(posedge clock) begin : monitor
      store_status_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %h at cycle %0d", rsp_tdata, cycle_count);
            end else begin
               want = expected_status.pop_front();
               if (rsp_tdata[0] !== want.success || rsp_tdata[7:1] !== want.entry_count ||
                   rsp_tdata[8] !== want.table_empty || rsp_tdata[16:9] !== want.smallest_key ||
                   rsp_tdata[RSP_W-1:17] !== '0) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch at cycle %0d: expected ok %0b count %0d empty %0b min %0d",
                              cycle_count, want.success, want.entry_count, want.table_empty,
                              want.smallest_key);
                     $display("   got ok %0b count %0d empty %0b min %0d pad %h",
                              rsp_tdata[0], rsp_tdata[7:1], rsp_tdata[8],
                              rsp_tdata[16:9], rsp_tdata[RSP_W-1:17]);
                  end
               end
            end
         end
         if (hold_left != 0 || hold_served != hold_requests) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int send_pct [PHASES];
      int recv_pct [PHASES];
      int phase_start;
      send_pct = '{0, 69, 0, 35};
      recv_pct = '{0, 0, 69, 35};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct  = send_pct[ph];
         recv_stall_pct = recv_pct[ph];
         phase_start    = n_queued;
         if (ph == 0) begin
            // remove from empty, extremes, duplicates, misses, back to empty
            queue_req(MODE_REMOVE, 8'd0);
            queue_req(MODE_INSERT, 8'd128);
            queue_req(MODE_INSERT, 8'd128);
            queue_req(MODE_INSERT, 8'd0);
            queue_req(MODE_INSERT, 8'd255);
            queue_req(MODE_INSERT, 8'd127);
            queue_req(MODE_INSERT, 8'd1);
            queue_req(MODE_REMOVE, 8'd5);
            queue_req(MODE_REMOVE, 8'd128);
            queue_req(MODE_REMOVE, 8'd128);
            queue_req(MODE_REMOVE, 8'd128);
            queue_req(MODE_REMOVE, 8'd0);
            queue_req(MODE_REMOVE, 8'd255);
            queue_req(MODE_REMOVE, 8'd127);
            queue_req(MODE_REMOVE, 8'd1);
            queue_req(MODE_REMOVE, 8'd255);
            queue_req(MODE_INSERT, 8'd255);
            queue_req(MODE_REMOVE, 8'd255);
            // long receiver hold while the store is filled past capacity
            hold_requests++;
            fill_store(1'b0, 0);
         end
         while (n_queued - phase_start < PHASE_ITEMS) random_burst();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
